// ----- design/tepq_pkg.sv -----
package tepq_pkg;

  // fixed widths of the item fields
  localparam int OP_W      = 2;
  localparam int SLOT_ID_W = 3;
  localparam int CYC_W     = 32;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_POP    = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  // update command to the queue order tracker
  typedef struct packed {
    logic ins;
    logic del;
  } order_upd_t;

endpackage

// ----- design/tepq_ram.sv -----
module tepq_ram #(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3,
  parameter int WIDTH  = 32
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/tepq_order.sv -----
module tepq_order #(
  parameter int NUM_SLOTS = 8,
  parameter int SLOT_W    = 3
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tepq_pkg::order_upd_t    upd_i,
  input  logic [SLOT_W-1:0]       upd_slot_i,
  input  logic [SLOT_W-1:0]       rd_row_i,
  input  logic [SLOT_W-1:0]       rd_col_i,
  output logic [NUM_SLOTS-1:0]    queued_o,
  output logic                    before_o
);
  import tepq_pkg::*;

  logic [NUM_SLOTS-1:0] queued_q;
  logic [NUM_SLOTS-1:0] before_q [NUM_SLOTS];

  // queued flags and insertion order matrix
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queued_q <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        before_q[i] <= '0;
      end
    end else if (upd_i.ins) begin
      // every other queued slot now precedes the new entry on a tie
      for (int j = 0; j < NUM_SLOTS; j++) begin
        if (j != int'(upd_slot_i) && queued_q[j]) begin
          before_q[j][upd_slot_i] <= 1'b1;
        end
      end
      before_q[upd_slot_i] <= '0;
      queued_q[upd_slot_i] <= 1'b1;
    end else if (upd_i.del) begin
      before_q[upd_slot_i] <= '0;
      queued_q[upd_slot_i] <= 1'b0;
    end
  end

  assign queued_o = queued_q;
  assign before_o = before_q[rd_row_i][rd_col_i];

endmodule

// ----- design/timed_event_priority_queue.sv -----
// after the input transfer the sequencer runs the scan, drain and done states, then loads the result
//   into the output register when it is free; a new item is taken only in idle, and the head scan
//   reads one deadline per cycle through the single read port of the deadline ram
// a finished result waits in the output register while the next item is taken
// reset: queue empty, no head, no pending result; the deadline ram is not cleared
module timed_event_priority_queue #(
  parameter int NUM_SLOTS  = 8,
  parameter int CYCLE_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tepq_pkg::OP_W-1:0]      op_i,
  input  logic [tepq_pkg::SLOT_ID_W-1:0] slot_id_i,
  input  logic [tepq_pkg::CYC_W-1:0]     due_cycle_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           popped_valid_o,
  output logic [tepq_pkg::SLOT_ID_W-1:0] popped_slot_o,
  output logic [tepq_pkg::CYC_W-1:0]     popped_cycle_o,
  output logic                           head_valid_o,
  output logic [tepq_pkg::SLOT_ID_W-1:0] head_slot_o,
  output logic [tepq_pkg::CYC_W-1:0]     head_cycle_o
);
  import tepq_pkg::*;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  state_e                state_q, state_d;
  logic                  in_fire;
  op_e                   op;
  logic                  slot_ok;
  logic [SLOT_W-1:0]     in_slot;

  order_upd_t            upd;
  logic [SLOT_W-1:0]     upd_slot;
  logic [NUM_SLOTS-1:0]  queued;
  logic                  before_bit;

  logic                  ram_we;
  logic                  ram_re;
  logic [CYCLE_BITS-1:0] ram_rdata;

  logic                  pop_take;
  logic                  pop_vld_q;
  logic [SLOT_W-1:0]     pop_slot_q;
  logic [CYCLE_BITS-1:0] pop_cyc_q;

  logic [SLOT_W-1:0]     cnt_q;
  logic                  cmp_vld_q;
  logic [SLOT_W-1:0]     cmp_idx_q;
  logic                  take;

  logic                  best_vld_q;
  logic [SLOT_W-1:0]     best_slot_q;
  logic [CYCLE_BITS-1:0] best_cyc_q;

  logic                  out_load;
  logic                  out_valid_q;
  logic                  o_pop_vld_q;
  logic [SLOT_ID_W-1:0]  o_pop_slot_q;
  logic [CYC_W-1:0]      o_pop_cyc_q;
  logic                  o_head_vld_q;
  logic [SLOT_ID_W-1:0]  o_head_slot_q;
  logic [CYC_W-1:0]      o_head_cyc_q;

  // input transfer decode
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign op         = op_e'(op_i);
  assign slot_ok    = int'(slot_id_i) < NUM_SLOTS;
  assign in_slot    = SLOT_W'(slot_id_i);

  // state updates issued at the input transfer; pop takes the current head
  always_comb begin
    upd      = '0;
    upd_slot = in_slot;
    ram_we   = 1'b0;
    pop_take = 1'b0;
    if (in_fire) begin
      case (op)
        OP_INSERT: begin
          if (slot_ok) begin
            upd.ins = 1'b1;
            ram_we  = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (slot_ok) begin
            upd.del = 1'b1;
          end
        end
        OP_POP: begin
          if (best_vld_q) begin
            upd.del  = 1'b1;
            upd_slot = best_slot_q;
            pop_take = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // deadline store; writes happen only at the transfer, reads only in the scan
  assign ram_re = (state_q == ST_SCAN);

  tepq_ram #(
    .DEPTH  (NUM_SLOTS),
    .ADDR_W (SLOT_W),
    .WIDTH  (CYCLE_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_slot),
    .wdata_i (CYCLE_BITS'(due_cycle_i)),
    .re_i    (ram_re),
    .raddr_i (cnt_q),
    .rdata_o (ram_rdata)
  );

  tepq_order #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_order (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .upd_i      (upd),
    .upd_slot_i (upd_slot),
    .rd_row_i   (cmp_idx_q),
    .rd_col_i   (best_slot_q),
    .queued_o   (queued),
    .before_o   (before_bit)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q == LAST_SLOT) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // a queued candidate beats the best so far: no best yet, earlier deadline, or older on a tie
  assign take = cmp_vld_q && queued[cmp_idx_q] &&
                (!best_vld_q || (ram_rdata < best_cyc_q) ||
                 ((ram_rdata == best_cyc_q) && before_bit));

  // control registers: state, scan counter, compare stage, head, pop flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_idx_q  <= '0;
      best_vld_q <= 1'b0;
      pop_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= (state_q == ST_SCAN);
      cmp_idx_q <= cnt_q;
      if (in_fire) begin
        cnt_q      <= '0;
        best_vld_q <= 1'b0;
        pop_vld_q  <= pop_take;
      end else begin
        if (state_q == ST_SCAN) begin
          cnt_q <= SLOT_W'(cnt_q + 1'b1);
        end
        if (take) begin
          best_vld_q <= 1'b1;
        end
      end
    end
  end

  // head and popped payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pop_slot_q <= pop_take ? best_slot_q : '0;
      pop_cyc_q  <= pop_take ? best_cyc_q : '0;
    end else if (take) begin
      best_slot_q <= cmp_idx_q;
      best_cyc_q  <= ram_rdata;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_pop_vld_q   <= pop_vld_q;
      o_pop_slot_q  <= SLOT_ID_W'(pop_slot_q);
      o_pop_cyc_q   <= CYC_W'(pop_cyc_q);
      o_head_vld_q  <= best_vld_q;
      o_head_slot_q <= best_vld_q ? SLOT_ID_W'(best_slot_q) : '0;
      o_head_cyc_q  <= best_vld_q ? CYC_W'(best_cyc_q) : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign popped_valid_o = o_pop_vld_q;
  assign popped_slot_o  = o_pop_slot_q;
  assign popped_cycle_o = o_pop_cyc_q;
  assign head_valid_o   = o_head_vld_q;
  assign head_slot_o    = o_head_slot_q;
  assign head_cycle_o   = o_head_cyc_q;

  // checks
  a_no_ram_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("deadline ram written during scan");

  a_head_iff_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (best_vld_q == (|queued)))
    else $error("head validity disagrees with queued flags");

  a_head_is_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && best_vld_q) |-> queued[best_slot_q])
    else $error("head slot not queued");

  a_popped_gone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && pop_vld_q) |-> !queued[pop_slot_q])
    else $error("popped slot still queued");

endmodule
